@@ rtl/afrg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package afrg_pkg;

	localparam int RING_AW = 5;
	localparam int WORD_W  = 32;
	localparam int RAND_W  = 31;
	localparam int DISC_W  = 9;

	localparam logic [WORD_W-1:0] PM_PRIME = 32'h7fff_ffff;
	localparam logic [14:0]       PM_MULT  = 15'd16807;

	// ring offsets for the two lags, modulo the ring depth
	localparam logic [RING_AW-1:0] LAG_LONG_OFS  = 5'd1;
	localparam logic [RING_AW-1:0] LAG_SHORT_OFS = 5'd29;

	localparam logic [RING_AW-1:0] SEQ_COPY_K     = 5'd2;
	localparam logic [RING_AW-1:0] SEQ_LAST_K     = 5'd30;
	localparam logic [RING_AW-1:0] SEQ0_ADDR      = 5'd31;
	localparam logic [RING_AW-1:0] SEQ1_ADDR      = 5'd0;
	localparam logic [RING_AW-1:0] COPY_ADDR      = 5'd1;
	localparam logic [RING_AW-1:0] IDX_AFTER_SEED = 5'd2;

	localparam int DISC_FIRST = 34;
	localparam int DISC_END   = 344;
	localparam logic [DISC_W-1:0] DISC_LAST = DISC_W'(DISC_END - DISC_FIRST - 1);

	localparam logic FUNC_DRAW   = 1'b0;
	localparam logic FUNC_RESEED = 1'b1;

	typedef struct packed {
		logic ld_seed;
		logic seed_one;
		logic wr_seq;
		logic wr_copy;
		logic ld_word;
		logic disc_init;
		logic wr_sum;
		logic emit;
	} afrg_cmd_t;

	typedef struct packed {
		logic k_copy;
		logic k_last;
		logic disc_last;
	} afrg_sts_t;

endpackage

`default_nettype wire

@@ rtl/afrg_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afrg_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  afrg_pkg::afrg_cmd_t            cmd,
	input  wire  [31:0]                    seed_value,
	output afrg_pkg::afrg_sts_t            sts,
	output logic [30:0]                    random_value
);
	import afrg_pkg::*;

	logic [WORD_W-1:0]  ring_mem [2**RING_AW];
	logic [WORD_W-1:0]  rd_long_q;
	logic [WORD_W-1:0]  rd_short_q;
	logic [RING_AW-1:0] idx_q;
	logic [RING_AW-1:0] k_q;
	logic [DISC_W-1:0]  disc_q;
	logic [WORD_W-1:0]  word_q;
	logic [RAND_W-1:0]  rand_q;

	logic [WORD_W-1:0]  sum;
	logic               we;
	logic [RING_AW-1:0] wa;
	logic [WORD_W-1:0]  wd;
	logic [RING_AW-1:0] seq_addr;

	// 16807 multiply mod 2^31-1, three register stages
	logic               neg_a;
	logic [WORD_W-1:0]  mag_a;
	logic [30:0]        lo_s1;
	logic [30:0]        hi_s1;
	logic               neg_s1;
	logic [WORD_W-1:0]  t_s2;
	logic               neg_s2;
	logic [WORD_W-1:0]  r_s3;
	logic               neg_s3;
	logic [WORD_W-1:0]  pm_res;

	assign neg_a = word_q[WORD_W-1];
	assign mag_a = neg_a ? (~word_q + 32'd1) : word_q;

	always_ff @(posedge clk) begin
		lo_s1  <= 31'(31'(PM_MULT) * 31'(mag_a[15:0]));
		hi_s1  <= 31'(31'(PM_MULT) * 31'(mag_a[31:16]));
		neg_s1 <= neg_a;
		t_s2   <= 32'(lo_s1) + {1'b0, hi_s1[14:0], 16'b0} + 32'(hi_s1[30:15]);
		neg_s2 <= neg_s1;
		r_s3   <= (t_s2 >= PM_PRIME) ? (t_s2 - PM_PRIME) : t_s2;
		neg_s3 <= neg_s2;
	end

	assign pm_res = (neg_s3 && (r_s3 != '0)) ? (PM_PRIME - r_s3) : r_s3;

	always_comb begin
		seq_addr = k_q;
		if (k_q == '0)
			seq_addr = SEQ0_ADDR;
		else if (k_q == 5'd1)
			seq_addr = SEQ1_ADDR;
	end

	assign sum = rd_long_q + rd_short_q;

	always_comb begin
		we = cmd.wr_seq | cmd.wr_copy | cmd.wr_sum;
		wa = idx_q;
		wd = word_q;
		if (cmd.wr_sum) begin
			wa = idx_q;
			wd = sum;
		end else if (cmd.wr_copy) begin
			wa = COPY_ADDR;
		end else if (cmd.wr_seq) begin
			wa = seq_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			ring_mem[wa] <= wd;
		rd_long_q  <= ring_mem[idx_q + LAG_LONG_OFS];
		rd_short_q <= ring_mem[idx_q + LAG_SHORT_OFS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			k_q    <= '0;
			disc_q <= '0;
		end else begin
			if (cmd.ld_seed)
				k_q <= '0;
			else if (cmd.ld_word)
				k_q <= k_q + 5'd1;
			if (cmd.disc_init) begin
				idx_q  <= IDX_AFTER_SEED;
				disc_q <= '0;
			end else if (cmd.wr_sum) begin
				idx_q  <= idx_q + 5'd1;
				disc_q <= disc_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_seed)
			word_q <= (cmd.seed_one || (seed_value == '0)) ? 32'd1 : seed_value;
		else if (cmd.ld_word)
			word_q <= pm_res;
		if (cmd.emit)
			rand_q <= sum[WORD_W-1:1];
	end

	assign sts.k_copy    = (k_q == SEQ_COPY_K);
	assign sts.k_last    = (k_q == SEQ_LAST_K);
	assign sts.disc_last = (disc_q == DISC_LAST);
	assign random_value  = rand_q;

endmodule

`default_nettype wire

@@ rtl/afrg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afrg_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  func,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  afrg_pkg::afrg_sts_t  sts,
	output afrg_pkg::afrg_cmd_t  cmd
);
	import afrg_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_SEED_WR = 11'b000_0000_0010,
		ST_COPY    = 11'b000_0000_0100,
		ST_PM_A    = 11'b000_0000_1000,
		ST_PM_B    = 11'b000_0001_0000,
		ST_PM_C    = 11'b000_0010_0000,
		ST_PM_D    = 11'b000_0100_0000,
		ST_DISC_RD = 11'b000_1000_0000,
		ST_DISC_WR = 11'b001_0000_0000,
		ST_DRAW_RD = 11'b010_0000_0000,
		ST_DRAW_WR = 11'b100_0000_0000
	} afrg_state_t;

	afrg_state_t state_q, state_nxt;
	logic        seeded_q;
	logic        draw_after_q;
	logic        out_valid_q;
	logic        out_free;
	logic        accept;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_RESEED) begin
						cmd.ld_seed = 1'b1;
						state_nxt   = ST_SEED_WR;
					end else if (!seeded_q) begin
						cmd.ld_seed  = 1'b1;
						cmd.seed_one = 1'b1;
						state_nxt    = ST_SEED_WR;
					end else begin
						state_nxt = ST_DRAW_RD;
					end
				end
			end
			ST_SEED_WR: begin
				cmd.wr_seq = 1'b1;
				if (sts.k_last) begin
					cmd.disc_init = 1'b1;
					state_nxt     = ST_DISC_RD;
				end else if (sts.k_copy) begin
					state_nxt = ST_COPY;
				end else begin
					state_nxt = ST_PM_A;
				end
			end
			ST_COPY: begin
				// the third sequence word also lands one place back
				cmd.wr_copy = 1'b1;
				state_nxt   = ST_PM_A;
			end
			ST_PM_A: state_nxt = ST_PM_B;
			ST_PM_B: state_nxt = ST_PM_C;
			ST_PM_C: state_nxt = ST_PM_D;
			ST_PM_D: begin
				cmd.ld_word = 1'b1;
				state_nxt   = ST_SEED_WR;
			end
			ST_DISC_RD: state_nxt = ST_DISC_WR;
			ST_DISC_WR: begin
				cmd.wr_sum = 1'b1;
				if (sts.disc_last)
					state_nxt = draw_after_q ? ST_DRAW_RD : ST_IDLE;
				else
					state_nxt = ST_DISC_RD;
			end
			ST_DRAW_RD: state_nxt = ST_DRAW_WR;
			ST_DRAW_WR: begin
				if (out_free) begin
					cmd.wr_sum = 1'b1;
					cmd.emit   = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seeded_q     <= 1'b0;
			draw_after_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.ld_seed)
				draw_after_q <= (func == FUNC_DRAW);
			if (cmd.disc_init)
				seeded_q <= 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/additive_feedback_random_generator_top.sv @@
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   func[0:0], seed_value[31:0]
// out       output     out_valid / out_stall random_value[30:0]
//
// a draw reads its two lag words from the ring memory into registers, adds them, writes the
// sum back and registers its upper 31 bits as the result; no new item is taken until it is done
// a reseed writes 31 sequence words, each new one made by the three-stage 16807 multiply
// mod 2^31-1 unit, then makes 310 discarded draws
// a draw before any seed runs a reseed with one first, then the draw
// reset clears index, seeded flag and control; the ring memory is not cleared
// a stalled result holds; the next item is taken while it waits
`timescale 1ns / 1ps
`default_nettype none

module additive_feedback_random_generator_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [0:0]  func,
	input  wire  [31:0] seed_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [30:0] random_value
);
	import afrg_pkg::*;

	afrg_cmd_t cmd;
	afrg_sts_t sts;

	afrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func[0]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	afrg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.seed_value   (seed_value),
		.sts          (sts),
		.random_value (random_value)
	);

endmodule

`default_nettype wire

@@ rtl/afrg_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afrg_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [30:0] random_value
);

	// a waiting result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_value))
		else $error("stalled result changed");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while busy");

	// a new result is only produced while the block is busy
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result with no item in flight");

endmodule

bind additive_feedback_random_generator_top afrg_chk u_afrg_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.random_value (random_value)
);

`default_nettype wire

@@ tb/additive_feedback_random_generator_top_test.sv @@
`timescale 1ns / 1ps

module additive_feedback_random_generator_top_test;
	import afrg_pkg::*;

	localparam logic [31:0] MERSENNE_31   = 32'h7fff_ffff;
	localparam logic [63:0] LCG_MULT      = 64'd16807;
	localparam logic [4:0]  LAG_A_OFS     = 5'd1;
	localparam logic [4:0]  LAG_B_OFS     = 5'd29;
	localparam logic [4:0]  POS_AFTER_FILL = 5'd2;
	localparam int          DISCARD_DRAWS = 310;
	localparam int          RANDOM_ITEMS  = 1130;
	localparam int          SETTLE_CYCLES = 1000;
	localparam int          SHOW_LIMIT    = 10;

	typedef struct {
		logic [0:0]  op;
		logic [31:0] seed;
		bit          hold;
	} gen_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [0:0]  func = FUNC_DRAW;
	logic [31:0] seed_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] random_value;

	gen_req_t    pending_reqs[$];
	logic [30:0] expected_numbers[$];
	logic [31:0] draws_sent = '0;
	logic [31:0] results_seen = '0;
	int          mismatch_count = 0;

	// own copy of the generator state
	logic [31:0] lfib_ring [32];
	logic [4:0]  lfib_pos;
	bit          lfib_primed;

	int send_gap;
	bit send_calm;
	int stall_left;
	bit recv_calm;

	additive_feedback_random_generator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value)
	);

	always #6 clk = ~clk;

	// signed word times 16807, non-negative residue mod 2^31-1
	function automatic logic [31:0] mulmod16807(input logic [31:0] w);
		logic [31:0] mag;
		logic [63:0] prod;
		logic [31:0] r;
		mag = w[31] ? (32'd0 - w) : w;
		prod = {32'd0, mag} * LCG_MULT;
		r = 32'(prod % {32'd0, MERSENNE_31});
		return (w[31] && r != 32'd0) ? MERSENNE_31 - r : r;
	endfunction

	function automatic logic [31:0] lfib_advance();
		logic [4:0]  a;
		logic [4:0]  b;
		logic [31:0] sum;
		a = lfib_pos + LAG_A_OFS;
		b = lfib_pos + LAG_B_OFS;
		sum = lfib_ring[a] + lfib_ring[b];
		lfib_ring[lfib_pos] = sum;
		lfib_pos = lfib_pos + 5'd1;
		return sum;
	endfunction

	function automatic void lfib_seed(input logic [31:0] s);
		logic [31:0] seq [31];
		logic [31:0] scrap;
		seq[0] = (s == 32'd0) ? 32'd1 : s;
		for (int k = 1; k < 31; k++)
			seq[k] = mulmod16807(seq[k-1]);
		for (int k = 2; k < 31; k++)
			lfib_ring[k] = seq[k];
		lfib_ring[31] = seq[0];
		lfib_ring[0] = seq[1];
		lfib_ring[1] = seq[2];
		lfib_pos = POS_AFTER_FILL;
		lfib_primed = 1'b1;
		for (int k = 0; k < DISCARD_DRAWS; k++)
			scrap = lfib_advance();
	endfunction

	function automatic logic [30:0] lfib_number();
		logic [31:0] word;
		if (!lfib_primed)
			lfib_seed(32'd1);
		word = lfib_advance();
		return word[31:1];
	endfunction

	task automatic add_req(input logic [0:0] op, input logic [31:0] seed, input bit hold);
		gen_req_t r;
		r.op = op;
		r.seed = seed;
		r.hold = hold;
		pending_reqs.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		gen_req_t    nxt;
		logic        busy;
		logic [31:0] sent_now;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_DRAW;
			seed_value <= '0;
			draws_sent <= '0;
			send_gap = 0;
			send_calm = 1'b0;
		end else begin
			busy = in_valid;
			sent_now = draws_sent;
			if (in_valid && !in_stall) begin
				busy = 1'b0;
				if (func == FUNC_DRAW)
					sent_now = sent_now + 32'd1;
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 5);
			end
			draws_sent <= sent_now;
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].hold && results_seen != sent_now)) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					func <= nxt.op;
					seed_value <= nxt.seed;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predicts on accepted items, checks accepted results
	always @(posedge clk or negedge arst_n) begin : watch_proc
		logic [30:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			results_seen <= '0;
			lfib_pos = '0;
			lfib_primed = 1'b0;
			expected_numbers.delete();
			stall_left = 0;
			recv_calm = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (func == FUNC_RESEED)
					lfib_seed(seed_value);
				else
					expected_numbers.push_back(lfib_number());
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 32'd1;
				if (expected_numbers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("%0t: unexpected random_value %h", $realtime, random_value);
				end else begin
					want = expected_numbers.pop_front();
					if (random_value !== want) begin
						mismatch_count++;
						if (mismatch_count <= SHOW_LIMIT)
							$display("%0t: random_value expected %h got %h",
								$realtime, want, random_value);
					end
				end
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				stall_left = recv_calm ? 0 : $urandom_range(0, 5);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	initial begin : stim_proc
		logic [31:0] corner_seeds [6];
		logic [0:0]  op;
		logic [31:0] seed;
		corner_seeds[0] = 32'h0000_0000;
		corner_seeds[1] = 32'h0000_0001;
		corner_seeds[2] = 32'hffff_ffff;
		corner_seeds[3] = 32'h8000_0000;
		corner_seeds[4] = 32'h7fff_ffff;
		corner_seeds[5] = 32'h8000_0001;

		// draw before any seed primes with one
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_req(FUNC_DRAW, 32'hffff_ffff, 1'b0);
		// zero seed is read as one
		add_req(FUNC_RESEED, 32'h0000_0000, 1'b0);
		add_req(FUNC_DRAW, 32'h1234_5678, 1'b0);
		add_req(FUNC_RESEED, 32'h0000_0001, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		// negative seeds take the signed residue
		add_req(FUNC_RESEED, 32'hffff_ffff, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_req(FUNC_RESEED, 32'h8000_0000, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		// seed equal to the modulus makes every later sequence word zero
		add_req(FUNC_RESEED, 32'h7fff_ffff, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_req(FUNC_DRAW, 32'hffff_ffff, 1'b0);
		add_req(FUNC_RESEED, 32'h8000_0001, 1'b1);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_req(FUNC_RESEED, 32'h7fff_fffe, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_req(FUNC_RESEED, 32'h0001_0000, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_req(FUNC_DRAW, 32'h0000_0000, 1'b1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op = ($urandom_range(0, 15) == 0) ? FUNC_RESEED : FUNC_DRAW;
			seed = $urandom;
			if (op == FUNC_RESEED && $urandom_range(0, 3) == 0)
				seed = corner_seeds[$urandom_range(0, 5)];
			add_req(op, seed, $urandom_range(0, 99) == 0);
		end
		add_req(FUNC_DRAW, $urandom, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || results_seen != draws_sent);
		// a reseed makes no result, so let any stray output show up
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_numbers.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog_proc
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
